// ----- rtl/kes_pkg.sv -----
// kes_pkg: shared types and constants for the kepler equation solver
// fixed-point constants in Q3.28, cordic arctangent table, register indexes
// no dependencies
package kes_pkg;

    localparam logic signed [33:0] Q28_ONE     = 34'sd268435456;
    localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

    // divider: 33-bit magnitude shifted left by 28
    localparam int DIV_BITS = 61;

    // configuration register indexes
    localparam logic REG_STEP_TOLERANCE  = 1'b0;
    localparam logic REG_ITERATION_LIMIT = 1'b1;

    // sine and cosine handed from the cordic unit to the sequencer
    typedef struct packed {
        logic               done;
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
    } kes_trig_t;

    // arctangent of 2^-i in Q28, rounded to nearest
    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] val;
        val = 32'sd0;
        unique case (idx)
            5'd0:  val = 32'sd210828714;
            5'd1:  val = 32'sd124459457;
            5'd2:  val = 32'sd65760959;
            5'd3:  val = 32'sd33381290;
            5'd4:  val = 32'sd16755422;
            5'd5:  val = 32'sd8385879;
            5'd6:  val = 32'sd4193963;
            5'd7:  val = 32'sd2097109;
            5'd8:  val = 32'sd1048571;
            5'd9:  val = 32'sd524287;
            5'd10: val = 32'sd262144;
            5'd11: val = 32'sd131072;
            5'd12: val = 32'sd65536;
            5'd13: val = 32'sd32768;
            5'd14: val = 32'sd16384;
            5'd15: val = 32'sd8192;
            5'd16: val = 32'sd4096;
            5'd17: val = 32'sd2048;
            5'd18: val = 32'sd1024;
            5'd19: val = 32'sd512;
            5'd20: val = 32'sd256;
            5'd21: val = 32'sd128;
            5'd22: val = 32'sd64;
            5'd23: val = 32'sd32;
            5'd24: val = 32'sd16;
            5'd25: val = 32'sd8;
            5'd26: val = 32'sd4;
            5'd27: val = 32'sd2;
            5'd28: val = 32'sd1;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/kes_cordic.sv -----
// kes_cordic: iterative rotation-mode cordic giving sine and cosine in Q28
// reduces the angle to [-pi, pi], folds to [-pi/2, pi/2], one rotation a cycle
// depends on kes_pkg
module kes_cordic import kes_pkg::*; #(
    parameter int STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] angle,
    output kes_trig_t          trig
);

    typedef enum logic [2:0] {
        C_IDLE   = 3'b001,
        C_FOLD   = 3'b010,
        C_ROTATE = 3'b100
    } cordic_state_t;

    cordic_state_t      state_reg, state_next;
    logic signed [33:0] a_reg, a_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic signed [33:0] a_in;
    logic signed [33:0] a_fold;
    logic signed [31:0] dx, dy, at;

    assign a_in = 34'(angle);
    assign dx   = y_reg >>> cnt_reg[4:0];
    assign dy   = x_reg >>> cnt_reg[4:0];
    assign at   = atan_q28(cnt_reg[4:0]);

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_fold     = a_reg;
        unique case (state_reg)
            C_IDLE: begin
                // one wrap by two pi covers the whole 32-bit angle range
                if (start) begin
                    if (a_in > Q28_PI) begin
                        a_next = a_in - Q28_TWO_PI;
                    end else if (a_in < -Q28_PI) begin
                        a_next = a_in + Q28_TWO_PI;
                    end else begin
                        a_next = a_in;
                    end
                    state_next = C_FOLD;
                end
            end
            C_FOLD: begin
                // fold into the right half plane, cosine changes sign
                flip_next = 1'b1;
                if (a_reg > Q28_HALF_PI) begin
                    a_fold = Q28_PI - a_reg;
                end else if (a_reg < -Q28_HALF_PI) begin
                    a_fold = -Q28_PI - a_reg;
                end else begin
                    flip_next = 1'b0;
                end
                z_next     = a_fold[31:0];
                x_next     = CORDIC_GAIN;
                y_next     = 32'sd0;
                cnt_next   = 6'd0;
                state_next = C_ROTATE;
            end
            C_ROTATE: begin
                if (cnt_reg == 6'(STEPS)) begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    if (!z_reg[31]) begin
                        x_next = x_reg - dx;
                        y_next = y_reg + dy;
                        z_next = z_reg - at;
                    end else begin
                        x_next = x_reg + dx;
                        y_next = y_reg - dy;
                        z_next = z_reg + at;
                    end
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg    <= a_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        cnt_reg  <= cnt_next;
    end

    assign trig.done    = done_reg;
    assign trig.sin_val = y_reg;
    assign trig.cos_val = flip_reg ? -x_reg : x_reg;

endmodule

// ----- rtl/kepler_equation_solver.sv -----
// kepler_equation_solver: newton solver for E - e*sin(E) = M in fixed point
// sequencer, shared multiplier and radix-2 divider; depends on kes_pkg, kes_cordic
//
//   channel   direction  ports
//   s_        in         s_valid s_ready s_mean_anomaly s_eccentricity
//   m_        out        m_valid m_ready m_eccentric_anomaly m_steps_used m_converged
//   cfg_      in         cfg_we cfg_addr cfg_wdata
//
// one newton step runs the cordic rotations and then the restoring divider;
// items are solved one at a time.
// synchronous active-low reset clears the stored anomaly to zero.
// a result waits in the output register; s_ready is low while an item is in work.
module kepler_equation_solver import kes_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [30:0]        s_mean_anomaly,
    input  logic [15:0]        s_eccentricity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_eccentric_anomaly,
    output logic [7:0]         m_steps_used,
    output logic               m_converged,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [27:0]        cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LAUNCH = 8'b0000_0010,
        ST_CORDIC = 8'b0000_0100,
        ST_MUL_S  = 8'b0000_1000,
        ST_MUL_C  = 8'b0001_0000,
        ST_DIVIDE = 8'b0010_0000,
        ST_UPDATE = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [27:0]        tol_reg;
    logic [7:0]         limit_reg;
    logic signed [31:0] anomaly_reg, anomaly_next;
    logic [30:0]        m_reg, m_next;
    logic [15:0]        ecc_reg, ecc_next;
    logic signed [34:0] f_reg, f_next;
    logic [30:0]        fp_reg, fp_next;
    logic [31:0]        rem_reg, rem_next;
    logic [60:0]        dq_reg, dq_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [7:0]         steps_reg, steps_next;
    logic               conv_reg, conv_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] out_e_reg, out_e_next;
    logic [7:0]         out_steps_reg, out_steps_next;
    logic               out_conv_reg, out_conv_next;

    kes_trig_t          trig;
    logic               cordic_start;
    logic signed [31:0] mul_b;
    logic signed [48:0] prod;
    logic signed [32:0] prod_floor;
    logic signed [33:0] fp_full;
    logic [34:0]        f_abs;
    logic [31:0]        trial;
    logic signed [63:0] delta;
    logic signed [63:0] e_new;
    logic signed [31:0] e_sat;
    logic [7:0]         steps_inc;
    logic [7:0]         limit_eff;
    logic               step_conv;

    kes_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (anomaly_reg),
        .trig    (trig)
    );

    assign cordic_start = (state_reg == ST_LAUNCH);
    assign s_ready      = (state_reg == ST_IDLE);

    // shared multiplier: e*sin then e*cos, floored by 16
    assign mul_b      = (state_reg == ST_MUL_S) ? trig.sin_val : trig.cos_val;
    assign prod       = $signed({1'b0, ecc_reg}) * mul_b;
    assign prod_floor = prod[48:16];
    assign fp_full    = Q28_ONE - 34'(prod_floor);
    assign f_abs      = f_reg[34] ? 35'(-f_reg) : 35'(f_reg);

    // restoring divider trial subtract
    assign trial = {rem_reg[30:0], dq_reg[60]};

    // newton update with saturation
    assign delta     = f_reg[34] ? -$signed({3'b000, dq_reg}) : $signed({3'b000, dq_reg});
    assign e_new     = 64'(anomaly_reg) - delta;
    assign steps_inc = steps_reg + 8'd1;
    assign limit_eff = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
    assign step_conv = (dq_reg <= 61'(tol_reg));

    always_comb begin
        if (e_new > 64'sd2147483647) begin
            e_sat = 32'sh7fffffff;
        end else if (e_new < -64'sd2147483648) begin
            e_sat = 32'sh80000000;
        end else begin
            e_sat = e_new[31:0];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        anomaly_next   = anomaly_reg;
        m_next         = m_reg;
        ecc_next       = ecc_reg;
        f_next         = f_reg;
        fp_next        = fp_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        div_cnt_next   = div_cnt_reg;
        steps_next     = steps_reg;
        conv_next      = conv_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_e_next     = out_e_reg;
        out_steps_next = out_steps_reg;
        out_conv_next  = out_conv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    m_next     = s_mean_anomaly;
                    ecc_next   = s_eccentricity;
                    steps_next = 8'd0;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: state_next = ST_CORDIC;
            ST_CORDIC: begin
                if (trig.done) begin
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                f_next     = 35'(anomaly_reg) - 35'(prod_floor) - 35'(m_reg);
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                fp_next      = (fp_full < 34'sd1) ? 31'd1 : fp_full[30:0];
                rem_next     = 32'd0;
                dq_next      = {f_abs[32:0], 28'd0};
                div_cnt_next = 6'd0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (trial >= {1'b0, fp_reg}) begin
                    rem_next = trial - {1'b0, fp_reg};
                    dq_next  = {dq_reg[59:0], 1'b1};
                end else begin
                    rem_next = trial;
                    dq_next  = {dq_reg[59:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DIV_BITS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                anomaly_next = e_sat;
                steps_next   = steps_inc;
                conv_next    = step_conv;
                if (step_conv || steps_inc >= limit_eff) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_e_next     = anomaly_reg;
                    out_steps_next = steps_reg;
                    out_conv_next  = conv_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            anomaly_reg <= 32'sd0;
            m_valid_reg <= 1'b0;
            tol_reg     <= 28'd2684;
            limit_reg   <= 8'd100;
        end else begin
            state_reg   <= state_next;
            anomaly_reg <= anomaly_next;
            m_valid_reg <= m_valid_next;
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_STEP_TOLERANCE:  tol_reg   <= cfg_wdata;
                    REG_ITERATION_LIMIT: limit_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        m_reg         <= m_next;
        ecc_reg       <= ecc_next;
        f_reg         <= f_next;
        fp_reg        <= fp_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        div_cnt_reg   <= div_cnt_next;
        steps_reg     <= steps_next;
        conv_reg      <= conv_next;
        out_e_reg     <= out_e_next;
        out_steps_reg <= out_steps_next;
        out_conv_reg  <= out_conv_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_eccentric_anomaly = out_e_reg;
    assign m_steps_used        = out_steps_reg;
    assign m_converged         = out_conv_reg;

endmodule

// ----- test/kepler_equation_solver_tb.sv -----
// kepler_equation_solver_tb: self-checking bench for the newton kepler solver
// predicts each beat with its own fixed-point newton and cordic model
// depends on kes_pkg and kepler_equation_solver
`timescale 1ns / 100ps

module kepler_equation_solver_tb;
    import kes_pkg::*;

    localparam int  CORDIC_ITERS = 24;
    localparam longint ONE_Q28   = 64'sd268435456;
    localparam longint PI_Q28    = 64'sd843314857;
    localparam longint TWO_PI_Q28 = 64'sd1686629713;
    localparam longint HALF_PI_Q28 = 64'sd421657428;
    localparam longint GAIN_Q28  = 64'sd163008219;
    localparam int  IDLE_LIMIT   = 200000;
    localparam int  DRAIN_CYCLES = 300;

    typedef struct {
        logic signed [31:0] anomaly;
        logic [7:0]         steps;
        logic               conv;
    } solution_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [30:0]        s_mean_anomaly;
    logic [15:0]        s_eccentricity;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_eccentric_anomaly;
    logic [7:0]         m_steps_used;
    logic               m_converged;
    logic               cfg_we;
    logic               cfg_addr;
    logic [27:0]        cfg_wdata;

    // predictor state and register copies
    longint    prev_anomaly;
    int unsigned tol_copy;
    int unsigned limit_copy;
    solution_t pending_solutions[$];
    int        error_count;
    int        idle_cycles;
    int        stall_left;
    longint    arctan_tab[32];

    kepler_equation_solver #(.CORDIC_STEPS(CORDIC_ITERS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mean_anomaly(s_mean_anomaly), .s_eccentricity(s_eccentricity),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_eccentric_anomaly(m_eccentric_anomaly), .m_steps_used(m_steps_used),
        .m_converged(m_converged),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        arctan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                       4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                       32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
                       16, 8, 4, 2, 1, 0, 0, 0};
    end

    // rotation-mode cordic with range reduction and fold
    function automatic void sin_cos(input longint angle, output longint s, output longint c);
        longint a, x, y, z, dx, dy;
        bit flip;
        a = angle;
        x = GAIN_Q28;
        y = 0;
        flip = 0;
        while (a > PI_Q28) a -= TWO_PI_Q28;
        while (a < -PI_Q28) a += TWO_PI_Q28;
        if (a > HALF_PI_Q28) begin
            a = PI_Q28 - a;
            flip = 1;
        end else if (a < -HALF_PI_Q28) begin
            a = -PI_Q28 - a;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < CORDIC_ITERS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end else begin
                x += dx; y -= dy; z += arctan_tab[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    // newton iteration from the stored anomaly; updates the stored anomaly
    function automatic solution_t solve_kepler(input logic [30:0] mean, input logic [15:0] ecc);
        solution_t   r;
        longint      m, e, ea, s, c, f, fp, delta, mag;
        int unsigned lim, steps;
        bit          conv;
        m = longint'({33'b0, mean});
        e = longint'({48'b0, ecc});
        ea = prev_anomaly;
        lim = (limit_copy == 0) ? 1 : limit_copy;
        steps = 0;
        do begin
            sin_cos(ea, s, c);
            f = ea - ((e * s) >>> 16) - m;
            fp = ONE_Q28 - ((e * c) >>> 16);
            if (fp < 1) fp = 1;
            delta = (f * ONE_Q28) / fp;
            ea -= delta;
            if (ea > 64'sd2147483647) ea = 64'sd2147483647;
            if (ea < -64'sd2147483648) ea = -64'sd2147483648;
            steps++;
            mag = delta < 0 ? -delta : delta;
            conv = mag <= longint'(tol_copy);
        end while (!conv && steps < lim);
        prev_anomaly = ea;
        r.anomaly = ea[31:0];
        r.steps = steps[7:0];
        r.conv = conv;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // random gap, mostly short with a few long
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one beat and record its expected solution
    task automatic send_item(input logic [30:0] mean, input logic [15:0] ecc);
        int gap;
        s_valid <= 1'b1;
        s_mean_anomaly <= mean;
        s_eccentricity <= ecc;
        do @(posedge aclk); while (!s_ready);
        pending_solutions.push_back(solve_kepler(mean, ecc));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // lower valid and wait until every solution is back
    task automatic drain();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [27:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_STEP_TOLERANCE) tol_copy = data;
        else limit_copy = data[7:0];
        @(posedge aclk);
    endtask

    function automatic logic [30:0] rand_mean();
        if ($urandom_range(0, 19) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 1686629713));
    endfunction

    function automatic logic [15:0] rand_ecc();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes of both fields under reset register values
    task automatic test_field_extremes();
        send_item(31'd0, 16'd0);
        send_item(31'd1686629713, 16'd0);
        send_item(31'd843314857, 16'd32768);
        send_item(31'd421657428, 16'd65535);
        send_item(31'd0, 16'd65535);
        send_item(31'd1686629713, 16'd65535);
        send_item(31'h7fffffff, 16'd0);
        send_item(31'd100, 16'd1);
        drain();
    endtask

    // tolerance and limit corners, zero limit treated as one
    task automatic test_register_corners();
        write_reg(REG_STEP_TOLERANCE, 28'd0);
        write_reg(REG_ITERATION_LIMIT, 28'd5);
        send_item(31'd500000000, 16'd20000);
        send_item(31'd0, 16'd0);
        drain();
        write_reg(REG_ITERATION_LIMIT, 28'd0);
        send_item(31'd1200000000, 16'd50000);
        send_item(31'd300000000, 16'd10000);
        drain();
        write_reg(REG_STEP_TOLERANCE, 28'hfffffff);
        write_reg(REG_ITERATION_LIMIT, 28'd255);
        send_item(31'd700000000, 16'd40000);
        send_item(31'd1500000000, 16'd65000);
        drain();
        write_reg(REG_STEP_TOLERANCE, 28'd1);
        write_reg(REG_ITERATION_LIMIT, 28'd1);
        send_item(31'd900000000, 16'd30000);
        drain();
    endtask

    // near-one eccentricity with out-of-range mean drives saturation
    task automatic test_saturation();
        write_reg(REG_STEP_TOLERANCE, 28'd2684);
        write_reg(REG_ITERATION_LIMIT, 28'd3);
        send_item(31'h7fffffff, 16'd65535);
        send_item(31'h7fffffff, 16'd65535);
        send_item(31'd0, 16'd65535);
        send_item(31'h40000000, 16'd65535);
        drain();
    endtask

    // random phases with fresh register settings between them
    task automatic test_random_phases();
        int n;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_STEP_TOLERANCE, 28'd1);
                1: write_reg(REG_STEP_TOLERANCE, 28'd2684);
                2: write_reg(REG_STEP_TOLERANCE, 28'hfffffff);
                default: write_reg(REG_STEP_TOLERANCE, 28'($urandom_range(1, 268435455)));
            endcase
            if (phase == 5) begin
                write_reg(REG_ITERATION_LIMIT, 28'd255);
                n = 20;
            end else begin
                write_reg(REG_ITERATION_LIMIT, 28'($urandom_range(1, 16)));
                n = 112;
            end
            for (int k = 0; k < n; k++) send_item(rand_mean(), rand_ecc());
            drain();
        end
    endtask

    // result checker with random backpressure
    always @(posedge aclk) begin
        solution_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_solutions.size() == 0) begin
                    report_mismatch("unexpected beat", m_eccentric_anomaly, 0);
                end else begin
                    want = pending_solutions.pop_front();
                    if (m_eccentric_anomaly !== want.anomaly)
                        report_mismatch("eccentric_anomaly", m_eccentric_anomaly, want.anomaly);
                    if (m_steps_used !== want.steps)
                        report_mismatch("steps_used", m_steps_used, want.steps);
                    if (m_converged !== want.conv)
                        report_mismatch("converged", m_converged, want.conv);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mean_anomaly = '0;
        s_eccentricity = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        prev_anomaly = 0;
        tol_copy = 2684;
        limit_copy = 100;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_register_corners();
        test_saturation();
        test_random_phases();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_solutions.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/kes_pkg.sv
rtl/kes_cordic.sv
rtl/kepler_equation_solver.sv
test/kepler_equation_solver_tb.sv
